>>> design/bc_pkg.sv
// package for the betweenness centrality engine: sequencer states, divider
// handshake structs and the saturating add; no dependencies
`timescale 1ns / 1ps
package bc_pkg;

  localparam int WORD = 32;
  localparam int DIST_W = 6;
  localparam int IDX_W = 5;
  localparam int DIV_STEPS = WORD;
  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRC_INIT,
    S_BFS_HEAD,
    S_BFS_SCAN,
    S_BK_HEAD,
    S_BK_SCAN,
    S_BK_WAIT,
    S_BK_CB,
    S_NEXT_SRC,
    S_OUT
  } bc_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHECK,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic            start;
    logic [WORD-1:0] a;
    logic [WORD-1:0] b;
    logic [WORD-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [WORD-1:0] quot;
  } md_rsp_t;

  // returns {saturated, sum}
  function automatic logic [WORD:0] sat_add(input logic [WORD-1:0] x,
                                            input logic [WORD-1:0] y);
    logic [WORD:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[WORD]) begin
      sat_add = {1'b1, {WORD{1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

endpackage

>>> design/betweenness_centrality.sv
// top level: adjacency store, per-source search state and the sequencer that
// runs breadth-first search and dependency accumulation; uses bc_pkg, bc_muldiv
//
//  channel | handshake              | payload
//  in_     | in_valid / in_ready    | row_index, adjacency_row, last_row
//  out_    | out_valid / out_ready  | node_index, centrality, saturated, last_result
//  cfg_    | cfg_valid / cfg_ready  | cfg_data (node_count)
//
// a row that is not last leaves the engine idle and ready for the next row; the last row starts the run and in_ready
// stays low until all n results are taken
// per source: every queued node is scanned over all n nodes, forward and
// backward, and each predecessor found takes a pass through the shared multiply/divide unit
// synchronous active-low reset; adjacency rows are not cleared by reset
`timescale 1ns / 1ps
module betweenness_centrality import bc_pkg::*; #(
  parameter int NODES = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_row_index,
  input  logic [WORD-1:0]   in_adjacency_row,
  input  logic              in_last_row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_node_index,
  output logic [WORD-1:0]   out_centrality,
  output logic              out_saturated,
  output logic              out_last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  localparam int DEPTH = (NODES < WORD) ? NODES : WORD;
  localparam int AW = $clog2(DEPTH);
  localparam logic [WORD-1:0] ONE = WORD'(1) << FRAC_BITS;

  bc_state_t state_r, state_nxt;

  logic [DIST_W-1:0] node_count_r;
  logic [DIST_W-1:0] n_use;

  logic [WORD-1:0]   adj_r   [DEPTH];
  logic [DIST_W-1:0] dist_r  [DEPTH];
  logic [WORD-1:0]   sigma_r [DEPTH];
  logic [WORD-1:0]   delta_r [DEPTH];
  logic [WORD-1:0]   cb_r    [DEPTH];
  logic [AW-1:0]     order_r [DEPTH];
  logic [DEPTH-1:0]  visited_r;
  logic              sat_r;

  logic [DIST_W-1:0] src_r, head_r, tail_r, k_r, jv_r;
  logic [AW-1:0]     f_r, w_r, src_idx, jidx;
  logic [DIST_W-1:0] dist_f_r, dist_w_r;
  logic [WORD-1:0]   sigma_f_r, sigma_w_r, delta_w_r, factor_r, row_f_r;

  logic        scan_last, edge_fwd, pred_ok, in_acc, out_acc;
  logic [WORD:0] sum_sig, sum_dep, sum_fac, sum_cb;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  bc_muldiv u_muldiv (
    .clk(clk),
    .rst_n(rst_n),
    .req(md_req),
    .rsp(md_rsp)
  );

  always_comb begin
    if (node_count_r == '0) n_use = DIST_W'(1);
    else if (node_count_r > DIST_W'(DEPTH)) n_use = DIST_W'(DEPTH);
    else n_use = node_count_r;
  end

  assign src_idx   = src_r[AW-1:0];
  assign jidx      = jv_r[AW-1:0];
  assign scan_last = (jv_r == n_use - 1'b1);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign edge_fwd  = row_f_r[jidx] && (jidx != f_r);
  assign pred_ok   = visited_r[jidx] && adj_r[jidx][w_r] && (jidx != w_r)
                     && (dist_r[jidx] + 1'b1 == dist_w_r);

  assign sum_sig = sat_add(sigma_r[jidx], sigma_f_r);
  assign sum_dep = sat_add(delta_r[jidx], md_rsp.quot);
  assign sum_fac = sat_add(ONE, delta_r[order_r[k_r[AW-1:0] - 1'b1]]);
  assign sum_cb  = sat_add(cb_r[w_r], delta_w_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_last_row) state_nxt = S_SRC_INIT;
      S_SRC_INIT: state_nxt = S_BFS_HEAD;
      S_BFS_HEAD: state_nxt = (head_r == tail_r) ? S_BK_HEAD : S_BFS_SCAN;
      S_BFS_SCAN: if (scan_last) state_nxt = S_BFS_HEAD;
      S_BK_HEAD: state_nxt = S_BK_SCAN;
      S_BK_SCAN: begin
        if (pred_ok) state_nxt = S_BK_WAIT;
        else if (scan_last) state_nxt = S_BK_CB;
      end
      S_BK_WAIT: if (md_rsp.done) state_nxt = scan_last ? S_BK_CB : S_BK_SCAN;
      S_BK_CB: state_nxt = (k_r == DIST_W'(1)) ? S_NEXT_SRC : S_BK_HEAD;
      S_NEXT_SRC: state_nxt = (src_r + 1'b1 == n_use) ? S_OUT : S_SRC_INIT;
      S_OUT: if (out_acc && scan_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    cfg_ready = 1'b1;
    md_req.start = (state_r == S_BK_SCAN) && pred_ok;
    md_req.a     = sigma_r[jidx];
    md_req.b     = factor_r;
    md_req.d     = sigma_w_r;
    out_node_index  = IDX_W'(jv_r);
    out_centrality  = cb_r[jidx];
    out_saturated   = sat_r;
    out_last_result = scan_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= DIST_W'(WORD);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((IDX_W + 2)'(in_row_index) < (IDX_W + 2)'(NODES)) begin
            adj_r[in_row_index[AW-1:0]] <= in_adjacency_row;
          end
          if (in_last_row) begin
            for (int i = 0; i < DEPTH; i++) cb_r[i] <= '0;
            sat_r <= 1'b0;
            src_r <= '0;
          end
        end
      end
      S_SRC_INIT: begin
        visited_r <= DEPTH'(1) << src_idx;
        dist_r[src_idx]  <= '0;
        sigma_r[src_idx] <= WORD'(1);
        delta_r[src_idx] <= '0;
        order_r[0] <= src_idx;
        head_r <= '0;
        tail_r <= DIST_W'(1);
      end
      S_BFS_HEAD: begin
        if (head_r == tail_r) begin
          k_r <= tail_r;
        end else begin
          f_r       <= order_r[head_r[AW-1:0]];
          dist_f_r  <= dist_r[order_r[head_r[AW-1:0]]];
          sigma_f_r <= sigma_r[order_r[head_r[AW-1:0]]];
          row_f_r   <= adj_r[order_r[head_r[AW-1:0]]];
          head_r    <= head_r + 1'b1;
          jv_r      <= '0;
        end
      end
      S_BFS_SCAN: begin
        if (edge_fwd) begin
          if (!visited_r[jidx]) begin
            visited_r[jidx] <= 1'b1;
            dist_r[jidx]    <= dist_f_r + 1'b1;
            sigma_r[jidx]   <= sigma_f_r;
            delta_r[jidx]   <= '0;
            order_r[tail_r[AW-1:0]] <= jidx;
            tail_r <= tail_r + 1'b1;
          end else if (dist_r[jidx] == dist_f_r + 1'b1) begin
            sigma_r[jidx] <= sum_sig[WORD-1:0];
            if (sum_sig[WORD]) sat_r <= 1'b1;
          end
        end
        jv_r <= jv_r + 1'b1;
      end
      S_BK_HEAD: begin
        w_r       <= order_r[k_r[AW-1:0] - 1'b1];
        dist_w_r  <= dist_r[order_r[k_r[AW-1:0] - 1'b1]];
        sigma_w_r <= sigma_r[order_r[k_r[AW-1:0] - 1'b1]];
        delta_w_r <= delta_r[order_r[k_r[AW-1:0] - 1'b1]];
        factor_r  <= sum_fac[WORD-1:0];
        if (sum_fac[WORD]) sat_r <= 1'b1;
        jv_r <= '0;
      end
      S_BK_SCAN: begin
        if (!pred_ok) jv_r <= jv_r + 1'b1;
      end
      S_BK_WAIT: begin
        if (md_rsp.done) begin
          delta_r[jidx] <= sum_dep[WORD-1:0];
          if (sum_dep[WORD] || md_rsp.ovf) sat_r <= 1'b1;
          jv_r <= jv_r + 1'b1;
        end
      end
      S_BK_CB: begin
        if (w_r != src_idx) begin
          cb_r[w_r] <= sum_cb[WORD-1:0];
          if (sum_cb[WORD]) sat_r <= 1'b1;
        end
        k_r <= k_r - 1'b1;
      end
      S_NEXT_SRC: begin
        src_r <= src_r + 1'b1;
        jv_r  <= '0;
      end
      S_OUT: begin
        if (out_acc) jv_r <= jv_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> design/bc_muldiv.sv
// shared multiply then restoring-divide unit: floor(a*b/d) saturated to 32 bits, zero when d is 0
// depends on bc_pkg
`timescale 1ns / 1ps
module bc_muldiv import bc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t state_r, state_nxt;
  logic [WORD-1:0]   a_r, b_r, d_r;
  logic [2*WORD-1:0] prod_r;
  logic [WORD-1:0]   rem_r, lo_r, quot_r;
  logic [STEP_W-1:0] cnt_r;
  logic              ovf_r;
  logic [WORD:0]     trial;
  logic              qbit;

  assign trial = {rem_r, lo_r[WORD-1]};
  assign qbit = (trial >= {1'b0, d_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_MUL;
      MD_MUL: state_nxt = MD_CHECK;
      MD_CHECK: begin
        if (d_r == '0 || prod_r[2*WORD-1:WORD] >= d_r) state_nxt = MD_DONE;
        else state_nxt = MD_DIV;
      end
      MD_DIV: if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == MD_DONE);
    rsp.ovf  = ovf_r;
    rsp.quot = quot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_r <= req.a;
          b_r <= req.b;
          d_r <= req.d;
        end
      end
      MD_MUL: prod_r <= a_r * b_r;
      MD_CHECK: begin
        cnt_r <= '0;
        if (d_r == '0) begin
          quot_r <= '0;
          ovf_r  <= 1'b0;
        end else if (prod_r[2*WORD-1:WORD] >= d_r) begin
          quot_r <= '1;
          ovf_r  <= 1'b1;
        end else begin
          quot_r <= '0;
          ovf_r  <= 1'b0;
          rem_r  <= prod_r[2*WORD-1:WORD];
          lo_r   <= prod_r[WORD-1:0];
        end
      end
      MD_DIV: begin
        if (qbit) begin
          rem_r <= WORD'(trial - {1'b0, d_r});
        end else begin
          rem_r <= trial[WORD-1:0];
        end
        lo_r   <= {lo_r[WORD-2:0], 1'b0};
        quot_r <= {quot_r[WORD-2:0], qbit};
        cnt_r  <= cnt_r + 1'b1;
      end
      MD_DONE: ;
      default: ;
    endcase
  end

endmodule

>>> bench/tb.sv
// testbench for betweenness_centrality: loads adjacency rows, runs the engine
// at several node counts and checks every centrality item against a
// predictor of its own; depends on bc_pkg and the design files
`timescale 1ns / 1ps
module tb;
  import bc_pkg::*;

  localparam int ITEM_GOAL = 410;
  localparam int IDLE_LIMIT = 2000000;
  localparam int MAXN = 32;

  typedef struct {
    bit [IDX_W-1:0] node;
    bit [WORD-1:0]  cent;
    bit             sat;
    bit             last;
  } cent_item_t;

  typedef struct {
    int             cfg;
    bit [IDX_W-1:0] row;
    bit [WORD-1:0]  adj;
    bit             last;
    bit             zero;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IDX_W-1:0]  in_row_index = '0;
  logic [WORD-1:0]   in_adjacency_row = '0;
  logic              in_last_row = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_node_index;
  logic [WORD-1:0]   out_centrality;
  logic              out_saturated;
  logic              out_last_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DIST_W-1:0] cfg_data = '0;

  betweenness_centrality #(.NODES(MAXN), .FRAC_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_row_index(in_row_index),
    .in_adjacency_row(in_adjacency_row), .in_last_row(in_last_row),
    .out_valid(out_valid), .out_ready(out_ready), .out_node_index(out_node_index),
    .out_centrality(out_centrality), .out_saturated(out_saturated),
    .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  bit [WORD-1:0]   adj_mem [MAXN];
  bit [DIST_W-1:0] node_cfg = 6'd32;
  bit [WORD-1:0]   hops [MAXN];
  bit              seen [MAXN];
  bit [WORD-1:0]   sigma [MAXN];
  bit [WORD-1:0]   delta [MAXN];
  bit [WORD-1:0]   cent_acc [MAXN];
  int              order [MAXN];
  bit              sat_flag;

  cent_item_t centrality_q[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  runs_done = 0;
  int  send_pct = 0;
  int  stall_pct = 0;
  int  hold_tokens = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  bit  typed_zero = 1'b0;

  function automatic int use_count();
    int n;
    n = int'(node_cfg);
    if (n == 0) n = 1;
    if (n > MAXN) n = MAXN;
    return n;
  endfunction

  function automatic bit [WORD-1:0] clip_sum(bit [WORD-1:0] a, bit [WORD-1:0] b);
    bit [WORD:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[WORD]) begin
      sat_flag = 1'b1;
      return '1;
    end
    return s[WORD-1:0];
  endfunction

  function automatic bit linked(int from, int to);
    if (from == to) return 1'b0;
    return adj_mem[from][to];
  endfunction

  function automatic void brandes_from(int src, int n);
    int head, tail, f, w;
    bit [WORD-1:0] factor;
    bit [63:0] q;
    head = 0;
    tail = 0;
    for (int i = 0; i < MAXN; i++) begin
      seen[i] = 0; sigma[i] = 0; delta[i] = 0; hops[i] = 0;
    end
    seen[src] = 1;
    sigma[src] = 1;
    order[tail++] = src;
    while (head < tail) begin
      f = order[head++];
      for (int j = 0; j < n; j++) begin
        if (linked(f, j)) begin
          if (!seen[j]) begin
            seen[j] = 1;
            hops[j] = hops[f] + 1;
            order[tail++] = j;
          end
          if (hops[j] == hops[f] + 1) sigma[j] = clip_sum(sigma[j], sigma[f]);
        end
      end
    end
    for (int k = tail; k > 0; k--) begin
      w = order[k-1];
      factor = clip_sum(32'h0001_0000, delta[w]);
      for (int v = 0; v < n; v++) begin
        if (seen[v] && linked(v, w) && hops[v] + 1 == hops[w]) begin
          q = 0;
          if (sigma[w] != 0) q = (64'(sigma[v]) * 64'(factor)) / 64'(sigma[w]);
          if (q > 64'hFFFF_FFFF) begin
            sat_flag = 1'b1;
            q = 64'hFFFF_FFFF;
          end
          delta[v] = clip_sum(delta[v], q[WORD-1:0]);
        end
      end
      if (w != src) cent_acc[w] = clip_sum(cent_acc[w], delta[w]);
    end
  endfunction

  function automatic void accumulate_centrality(bit [IDX_W-1:0] row, bit [WORD-1:0] adj,
                                                bit last, bit zero);
    int n;
    cent_item_t it;
    adj_mem[row] = adj;
    if (!last) return;
    n = use_count();
    sat_flag = 0;
    for (int i = 0; i < MAXN; i++) cent_acc[i] = 0;
    for (int s = 0; s < n; s++) brandes_from(s, n);
    for (int i = 0; i < n; i++) begin
      it.node = i[IDX_W-1:0];
      it.cent = zero ? '0 : cent_acc[i];
      it.sat = zero ? 1'b0 : sat_flag;
      it.last = (i == n - 1);
      centrality_q = {centrality_q, it};
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      accumulate_centrality(in_row_index, in_adjacency_row, in_last_row, typed_zero);
  end

  always @(posedge clk) begin
    cent_item_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (centrality_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: node %0d centrality %h",
                                   out_node_index, out_centrality);
      end else begin
        e = centrality_q.pop_front();
        if (out_node_index !== e.node || out_centrality !== e.cent ||
            out_saturated !== e.sat || out_last_result !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("bad item: exp node %0d cent %h sat %b last %b, got %0d %h %b %b",
                     e.node, e.cent, e.sat, e.last, out_node_index, out_centrality,
                     out_saturated, out_last_result);
        end
      end
    end
  end

  // receiver with random stalls and a single long hold-off
  always @(posedge clk) begin
    if (hold_tokens != hold_seen) begin
      hold_seen = hold_tokens;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("betweenness_centrality: mismatch");
        $finish;
      end
    end
  end

  task automatic send_row(bit [IDX_W-1:0] row, bit [WORD-1:0] adj, bit last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_index <= row;
    in_adjacency_row <= adj;
    in_last_row <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (centrality_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(bit [DIST_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_cfg = v;
  endtask

  dir_row_t dir_rows [0:16] = '{
    '{0,  5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1},
    '{3,  5'd1,  32'h0000_0004, 1'b0, 1'b0},
    '{-1, 5'd2,  32'h0000_0000, 1'b0, 1'b0},
    '{-1, 5'd0,  32'h0000_0002, 1'b1, 1'b0},
    '{4,  5'd0,  32'h0000_0006, 1'b0, 1'b0},
    '{-1, 5'd1,  32'h0000_0008, 1'b0, 1'b0},
    '{-1, 5'd2,  32'h0000_0008, 1'b0, 1'b0},
    '{-1, 5'd3,  32'h0000_0000, 1'b1, 1'b0},
    '{-1, 5'd3,  32'hFFFF_FFF8, 1'b1, 1'b0},
    '{1,  5'd0,  32'h0000_0000, 1'b1, 1'b1},
    '{8,  5'd4,  32'h0000_00F0, 1'b0, 1'b0},
    '{-1, 5'd5,  32'h0000_0001, 1'b0, 1'b0},
    '{-1, 5'd6,  32'h0000_0001, 1'b0, 1'b0},
    '{-1, 5'd7,  32'h0000_0001, 1'b0, 1'b0},
    '{-1, 5'd31, 32'h8000_0000, 1'b0, 1'b0},
    '{-1, 5'd0,  32'h0000_0010, 1'b1, 1'b0},
    '{-1, 5'd1,  32'h0000_0000, 1'b1, 1'b0}
  };

  initial begin
    int n, rows, big_runs, run_idx;
    bit [WORD-1:0] mask;
    bit [DIST_W-1:0] extremes [4] = '{6'd63, 6'd32, 6'd1, 6'd0};
    big_runs = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) write_node_count(dir_rows[i].cfg[DIST_W-1:0]);
      typed_zero = dir_rows[i].zero;
      send_row(dir_rows[i].row, dir_rows[i].adj, dir_rows[i].last);
    end
    typed_zero = 1'b0;

    // complete graph over every row at the largest count
    write_node_count(6'd63);
    for (int r = 0; r < MAXN; r++) send_row(r[IDX_W-1:0], '1, r == MAXN - 1);

    run_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      case (run_idx % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 48; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 48; end
        default: begin send_pct = 19; stall_pct = 19; end
      endcase
      if (run_idx % 3 == 0) begin
        if (run_idx % 12 == 0) write_node_count(extremes[(run_idx / 12) % 4]);
        else write_node_count(DIST_W'($urandom_range(2, 10)));
        if (use_count() == MAXN) begin
          big_runs++;
          if (big_runs > 2) write_node_count(DIST_W'($urandom_range(1, 12)));
        end
      end
      n = use_count();
      if (n == MAXN) begin
        // sparse rewrite keeps the large run short
        for (int r = 0; r < MAXN; r++)
          send_row(r[IDX_W-1:0], $urandom & $urandom & $urandom & $urandom, 1'b0);
      end
      if (run_idx == 4) hold_tokens++;
      rows = $urandom_range(0, 5);
      for (int k = 0; k <= rows; k++) begin
        if (n == MAXN) mask = $urandom & $urandom & $urandom & $urandom;
        else if ($urandom_range(3) == 0) mask = $urandom & $urandom;
        else mask = $urandom;
        send_row(IDX_W'(($urandom_range(3) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, n - 1)),
                 mask, k == rows);
      end
      if (run_idx % 7 == 6) drain();
      run_idx++;
      runs_done++;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d input items over %0d runs, %0d centrality items checked",
             items_sent, runs_done + 8, results_seen);
    if (errors == 0 && centrality_q.size() == 0) begin
      $display("betweenness_centrality: match");
    end else begin
      $display("%0d mismatches, %0d items still expected", errors, centrality_q.size());
      $display("betweenness_centrality: mismatch");
    end
    $finish;
  end

endmodule

>>> betweenness_centrality.f
design/bc_pkg.sv
design/bc_muldiv.sv
design/betweenness_centrality.sv
bench/tb.sv
